@@ design/fnv1k_pkg.sv @@
// Shared constants, types and the offset-basis table of the 1024-bit FNV-1a hash.
package fnv1k_pkg;

	localparam int HASH_WORDS = 16;
	localparam int WORD_W     = 64;
	localparam int IDX_W      = 4;
	localparam int OP_W       = 2;
	localparam int BYTE_W     = 8;

	// FNV-1024 prime = 2^680 + 0x18D
	localparam int             PRIME_LO_W    = 9;
	localparam logic [8:0]     PRIME_LO      = 9'h18D;
	localparam int             PRIME_HI_EXP  = 680;
	localparam int             PRIME_HI_WORD = PRIME_HI_EXP / WORD_W;
	localparam int             PRIME_HI_BIT  = PRIME_HI_EXP % WORD_W;
	// words of the old value that the shifted term reaches
	localparam int             SAVE_WORDS    = HASH_WORDS - PRIME_HI_WORD;

	// running carry of the word-serial multiply stays below 2^10
	localparam int CARRY_W = 10;
	localparam int SUM_W   = WORD_W + CARRY_W;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CARRY_W-1:0] carry_t;

	localparam op_t OP_ABSORB = 2'd0;
	localparam op_t OP_INIT   = 2'd1;
	localparam op_t OP_READ   = 2'd2;

	// FNV-1024 offset basis, little-endian 64-bit words
	function automatic word_t offset_word(idx_t idx);
		word_t w;
		case (idx)
			4'd0:    w = 64'haff4b16c71ee90b3;
			4'd1:    w = 64'h6bde8cc9c6a93b21;
			4'd2:    w = 64'h555f256cc005ae55;
			4'd3:    w = 64'heb6e73802734510a;
			4'd4:    w = 64'h000000000004c6d7;
			4'd10:   w = 64'h9a21d90000000000;
			4'd11:   w = 64'h6c3bf34eda3674da;
			4'd12:   w = 64'h4b29fc4223fdada1;
			4'd13:   w = 64'h32e56d5a591028b7;
			4'd14:   w = 64'h005f7a76758ecc4d;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

@@ design/fnv1k_req_if.sv @@
// Request channel: operation code and message byte.
interface fnv1k_req_if;
	import fnv1k_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 operation;
	logic [BYTE_W-1:0]   data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

@@ design/fnv1k_rsp_if.sv @@
// Response channel: one 64-bit hash word per handshake, sixteen per read request.
interface fnv1k_rsp_if;
	import fnv1k_pkg::*;

	logic    valid;
	logic    ready;
	word_t   hash_word;
	idx_t    word_index;
	logic    last_word;

	modport source (output valid, output hash_word, output word_index, output last_word,
		input ready);
	modport sink   (input valid, input hash_word, input word_index, input last_word,
		output ready);
endinterface

@@ design/fnv1k_mul_word.sv @@
// Shared word unit: one 64-bit word of hash * FNV prime with running carry.
module fnv1k_mul_word (
	input  fnv1k_pkg::word_t  cur_word,   // h[k], byte already folded in
	input  logic              hi_en,      // shifted term reaches this word
	input  fnv1k_pkg::word_t  hi_word,    // h[k - PRIME_HI_WORD]
	input  fnv1k_pkg::word_t  lo_word,    // h[k - PRIME_HI_WORD - 1], zero below
	input  fnv1k_pkg::carry_t carry_in,
	output fnv1k_pkg::word_t  sum_word,
	output fnv1k_pkg::carry_t carry_out
);
	import fnv1k_pkg::*;

	logic [WORD_W+PRIME_LO_W-1:0] prod;
	word_t                        shifted;
	logic [SUM_W-1:0]             sum;

	// low part of the prime is a 9-bit constant
	assign prod = {{PRIME_LO_W{1'b0}}, cur_word} * {{WORD_W{1'b0}}, PRIME_LO};

	// word k of (h << 680)
	assign shifted = hi_en ? ((hi_word << PRIME_HI_BIT) | (lo_word >> (WORD_W - PRIME_HI_BIT)))
		: '0;

	assign sum = SUM_W'(prod) + SUM_W'(shifted) + SUM_W'(carry_in);

	assign sum_word  = sum[WORD_W-1:0];
	assign carry_out = sum[SUM_W-1:WORD_W];
endmodule

@@ design/fnv1a_1024_hash.sv @@
// Top level of the 1024-bit FNV-1a hash: sequencer, hash ring and readout register.
//
// Keeps a running 1024-bit FNV-1a hash as 16 little-endian 64-bit words,
// loaded with the FNV-1024 offset basis at reset. Each request carries an
// operation: absorb XORs data_byte into the low byte and multiplies the value
// by the FNV-1024 prime (2^680 + 0x18D) modulo 2^1024; init reloads the
// offset basis; read out returns 16 responses, word 0 first, last_word set on
// word 15; code 3 is dropped. An absorb is done as 16 passes of one shared
// 64x9 multiply-add word unit, one hash word per cycle with the carry held
// between passes. A read out loads the words in turn into the response
// register, holding while the response side stalls; the response register
// lets the last word wait while a new request is taken. req.ready is low
// while an absorb or read out is in progress.
module fnv1a_1024_hash (
	input  logic              clk,
	input  logic              arst_n,
	fnv1k_req_if.sink         req,
	fnv1k_rsp_if.source       rsp
);
	import fnv1k_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_READ
	} state_t;

	state_t             state_q;
	idx_t               cnt_q;
	logic [BYTE_W-1:0]  byte_q;
	carry_t             carry_q;
	word_t              ring_q [HASH_WORDS];  // ring_q[0] is the word being worked on
	word_t              save_q [SAVE_WORDS];  // low words of the pre-multiply value
	word_t              prv_q;                // h[k-11] for the shifted term

	logic   req_acc;
	logic   last_step;
	logic   hi_en;
	logic   save_shift;
	word_t  cur_word;
	word_t  sum_word;
	carry_t carry_nxt;

	word_t  rsp_word_q;
	idx_t   rsp_idx_q;
	logic   rsp_last_q;
	logic   rsp_valid_q;
	logic   rsp_load;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign last_step = (cnt_q == IDX_W'(HASH_WORDS - 1));

	// byte is folded into word 0 on the first pass only
	assign cur_word  = ring_q[0] ^ ((cnt_q == '0) ? {{(WORD_W-BYTE_W){1'b0}}, byte_q} : '0);
	assign hi_en     = (cnt_q >= IDX_W'(PRIME_HI_WORD));
	// save line fills during the low passes and drains during the high ones
	assign save_shift = (cnt_q < IDX_W'(SAVE_WORDS)) || hi_en;

	fnv1k_mul_word u_mul (
		.cur_word  (cur_word),
		.hi_en     (hi_en),
		.hi_word   (save_q[0]),
		.lo_word   (prv_q),
		.carry_in  (carry_q),
		.sum_word  (sum_word),
		.carry_out (carry_nxt)
	);

	assign rsp_load = (state_q == ST_READ) && (!rsp_valid_q || rsp.ready);

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new word replaces the one taken this cycle
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (req_acc && req.operation == OP_ABSORB) begin
						state_q <= ST_ABSORB;
					end else if (req_acc && req.operation == OP_READ) begin
						state_q <= ST_READ;
					end
				end
				ST_ABSORB: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (rsp_load) begin
						cnt_q <= cnt_q + 1'b1;
						if (last_step) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hash ring: rotates one word per pass, result or old word enters at the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				ring_q[i] <= offset_word(IDX_W'(i));
			end
		end else if (req_acc && req.operation == OP_INIT) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				ring_q[i] <= offset_word(IDX_W'(i));
			end
		end else if (state_q == ST_ABSORB || rsp_load) begin
			for (int i = 0; i < HASH_WORDS - 1; i++) begin
				ring_q[i] <= ring_q[i+1];
			end
			ring_q[HASH_WORDS-1] <= (state_q == ST_ABSORB) ? sum_word : ring_q[0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			byte_q  <= req.data_byte;
			carry_q <= '0;
			prv_q   <= '0;
		end else if (state_q == ST_ABSORB) begin
			carry_q <= carry_nxt;
			if (hi_en) begin
				prv_q <= save_q[0];
			end
		end
		if (state_q == ST_ABSORB && save_shift) begin
			for (int i = 0; i < SAVE_WORDS - 1; i++) begin
				save_q[i] <= save_q[i+1];
			end
			save_q[SAVE_WORDS-1] <= cur_word;
		end
		if (rsp_load) begin
			rsp_word_q <= ring_q[0];
			rsp_idx_q  <= cnt_q;
			rsp_last_q <= last_step;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hash_word  = rsp_word_q;
	assign rsp.word_index = rsp_idx_q;
	assign rsp.last_word  = rsp_last_q;

	// no new request is taken on the cycle after an absorb or read out starts
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req.operation == OP_ABSORB || req.operation == OP_READ) |=> !req.ready)
		else $error("request taken while sequencer busy");

	// the last-word flag only rides on the top word
	a_last_ends_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.last_word |-> rsp.word_index == IDX_W'(HASH_WORDS - 1))
		else $error("last word out of sequence");

	// first multiply pass starts from a clean carry and empty shifted term
	a_absorb_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ABSORB && cnt_q == '0 |-> carry_q == '0 && prv_q == '0)
		else $error("absorb started with stale carry");

	// response register only fills while reading out
	a_rsp_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q) == ST_READ)
		else $error("response without read out");
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the 1024-bit FNV-1a hash block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fnv1k_pkg::*;

	localparam op_t OP_UNUSED       = 2'd3;
	localparam int  CLK_PERIOD      = 12;
	localparam int  RESET_CYCLES    = 3;
	localparam int  CYCLE_LIMIT     = 400000;
	localparam int  DRAIN_CYCLES    = 48;
	localparam int  SQUEEZE_CYCLES  = 400;
	localparam int  ITEMS_PER_PHASE = 62;
	localparam int  DIGEST_W        = HASH_WORDS * WORD_W;

	typedef logic [DIGEST_W-1:0] digest_t;

	typedef struct packed {
		word_t hash_word;
		idx_t  word_index;
		logic  last_word;
	} digest_word_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
		logic              pinned;
	} directed_row_t;

	localparam logic PINNED    = 1'b1;
	localparam logic PREDICTED = 1'b0;

	// offset basis typed in, most significant word first
	localparam digest_t BASIS_PINNED = {
		64'h0000000000000000, 64'h005f7a76758ecc4d, 64'h32e56d5a591028b7,
		64'h4b29fc4223fdada1, 64'h6c3bf34eda3674da, 64'h9a21d90000000000,
		64'h0000000000000000, 64'h0000000000000000, 64'h0000000000000000,
		64'h0000000000000000, 64'h0000000000000000, 64'h000000000004c6d7,
		64'heb6e73802734510a, 64'h555f256cc005ae55, 64'h6bde8cc9c6a93b21,
		64'haff4b16c71ee90b3};

	// pinned rows read back the offset basis: after reset, after init, after a dropped code
	localparam directed_row_t DIRECTED_ROWS [0:21] = '{
		{OP_READ,   8'h00, PINNED},
		{OP_UNUSED, 8'hFF, PREDICTED},
		{OP_READ,   8'h00, PINNED},
		{OP_ABSORB, 8'h00, PREDICTED},
		{OP_READ,   8'h00, PREDICTED},
		{OP_READ,   8'hFF, PREDICTED},
		{OP_ABSORB, 8'hFF, PREDICTED},
		{OP_ABSORB, 8'h80, PREDICTED},
		{OP_ABSORB, 8'h01, PREDICTED},
		{OP_READ,   8'h00, PREDICTED},
		{OP_INIT,   8'h5A, PREDICTED},
		{OP_READ,   8'h00, PINNED},
		{OP_UNUSED, 8'h00, PREDICTED},
		{OP_ABSORB, 8'hAA, PREDICTED},
		{OP_ABSORB, 8'h55, PREDICTED},
		{OP_READ,   8'h00, PREDICTED},
		{OP_INIT,   8'hFF, PREDICTED},
		{OP_INIT,   8'h00, PREDICTED},
		{OP_READ,   8'h00, PINNED},
		{OP_ABSORB, 8'h7F, PREDICTED},
		{OP_ABSORB, 8'hFE, PREDICTED},
		{OP_READ,   8'h00, PREDICTED}
	};

	logic clk = 1'b0;
	logic arst_n;

	fnv1k_req_if req ();
	fnv1k_rsp_if rsp ();

	fnv1a_1024_hash u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// hash predictor and the words it still owes
	digest_t      fnv_prime;
	digest_t      fnv_basis;
	digest_t      running_digest;
	digest_word_t words_due [$];

	int   errors        = 0;
	int   send_idle_pct = 0;
	int   stall_pct     = 0;
	logic hold_rsp      = 1'b0;
	logic squeeze_go    = 1'b0;

	function automatic digest_t decimal_to_digest(string digits);
		digest_t     acc;
		logic [7:0]  ch;
		acc = '0;
		for (int i = 0; i < digits.len(); i++) begin
			ch = digits[i];
			if (ch >= "0" && ch <= "9")
				acc = acc * 10 + (ch - "0");
		end
		return acc;
	endfunction

	// offer one request, with an optional idle gap first; predict on acceptance
	task automatic offer_request(input op_t op, input logic [BYTE_W-1:0] b, input logic pinned);
		int      gap;
		digest_t shown;
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.data_byte <= b;
		do @(posedge clk); while (!req.ready);
		case (op)
			OP_ABSORB: begin
				running_digest[BYTE_W-1:0] ^= b;
				running_digest = running_digest * fnv_prime;
			end
			OP_INIT: begin
				running_digest = fnv_basis;
			end
			OP_READ: begin
				shown = pinned ? BASIS_PINNED : running_digest;
				for (int w = 0; w < HASH_WORDS; w++)
					words_due.push_back({shown[w*WORD_W +: WORD_W], idx_t'(w),
						w == HASH_WORDS - 1});
			end
			default: ;  // unused code: dropped, no state change
		endcase
	endtask

	// response side: check each word, then pick ready for the next edge
	initial begin : collect
		digest_word_t want;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				if (words_due.size() == 0) begin
					$error("unexpected response: hash_word %h word_index %0d last_word %0b",
						rsp.hash_word, rsp.word_index, rsp.last_word);
					errors++;
				end else begin
					want = words_due.pop_front();
					if (rsp.hash_word !== want.hash_word) begin
						$error("hash_word: expected %h, got %h", want.hash_word, rsp.hash_word);
						errors++;
					end
					if (rsp.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d", want.word_index,
							rsp.word_index);
						errors++;
					end
					if (rsp.last_word !== want.last_word) begin
						$error("last_word: expected %0b, got %0b", want.last_word,
							rsp.last_word);
						errors++;
					end
				end
			end
			rsp.ready <= !hold_rsp && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// long response hold-off so the read path backs up into the request side
	initial begin : squeeze
		int held;
		wait (squeeze_go === 1'b1);
		@(posedge clk);
		hold_rsp <= 1'b1;
		for (held = 0; held < SQUEEZE_CYCLES; held++)
			@(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[fnv1a_1024_hash] ERROR");
		$finish;
	end

	initial begin : stimulus
		int     counted;
		int     burst;
		op_t    op;
		arst_n        <= 1'b0;
		req.valid     <= 1'b0;
		req.operation <= OP_ABSORB;
		req.data_byte <= '0;
		fnv_prime = decimal_to_digest({"5016456510113118655434598811035278955030765345404790744",
			"303017523831112055108147451509157692220295382716162651878526895249385292291816",
			"524375083746691371804094271873160484737966720260389217684476157468082573"});
		fnv_basis = decimal_to_digest({"14197795064947621068722070641403218320880622795441933",
			"960878474914617582723252296732303717722150864096521202355549365628174669108571",
			"814760471015076148029755969804077320157692458563003215304957150157403644460363",
			"550505412711285966361610267868082893823963790439336411086884584107735010676915"});
		running_digest = fnv_basis;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, no idling
		foreach (DIRECTED_ROWS[i])
			offer_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].pinned);

		// random phases: none, sender idle, receiver stall, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct <= 0;  end
				1: begin send_idle_pct = 63; stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  stall_pct <= 63; end
				default: begin send_idle_pct = 17; stall_pct <= 17; end
			endcase
			counted = 0;
			if (phase == 0) begin
				// reads back to back while the receiver holds off
				squeeze_go <= 1'b1;
				offer_request(OP_READ, 8'($urandom_range(0, 255)), PREDICTED);
				offer_request(OP_READ, 8'($urandom_range(0, 255)), PREDICTED);
				counted = 2;
			end
			while (counted < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 70) begin
					// message: optional init, a few bytes, then read back
					if ($urandom_range(0, 1) == 1) begin
						offer_request(OP_INIT, 8'($urandom_range(0, 255)), PREDICTED);
						counted++;
					end
					burst = $urandom_range(1, 8);
					repeat (burst)
						offer_request(OP_ABSORB, 8'($urandom_range(0, 255)), PREDICTED);
					offer_request(OP_READ, 8'($urandom_range(0, 255)), PREDICTED);
					counted += burst + 1;
				end else begin
					// loose request of any code, the unused one included
					op = op_t'($urandom_range(0, 3));
					offer_request(op, 8'($urandom_range(0, 255)), PREDICTED);
					if (op != OP_UNUSED)
						counted++;
				end
			end
		end
		req.valid <= 1'b0;

		while (words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[fnv1a_1024_hash] OK");
		else
			$display("[fnv1a_1024_hash] ERROR");
		$finish;
	end

endmodule
